FILE: design/wpm_pkg.sv
// Package for the wildcard pattern matcher: command codes, pattern byte
// codes, controller states and the command/status bundles between units.
// No dependencies.
`default_nettype none

package wpm_pkg;

    // Default size of the pattern store, in bytes.
    localparam int PATTERN_MAX_DEF = 64;

    // Request command codes.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_TEXT   = 2'd2;
    localparam logic [1:0] CMD_END    = 2'd3;

    // Pattern bytes with a special meaning.
    localparam logic [7:0] STAR_BYTE  = 8'd42;
    localparam logic [7:0] QMARK_BYTE = 8'd63;

    // Controller states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_END_READ,
        ST_END_OUT
    } wpm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_char;   // capture the text byte
        logic clear_pat;   // empty the pattern and clear overflow
        logic append;      // append the request byte to the pattern
        logic scan_start;  // restart the position counter at zero
        logic scan_rearm;  // scan mode: rearm (1) or advance (0)
        logic issue;       // read the current position this cycle
        logic end_addr;    // point the position counter at the pattern end
        logic out_load;    // load the result register
    } wpm_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_issue;  // position counter equals pattern length
        logic out_free;    // result register can take a new result
    } wpm_stat_t;

endpackage

`default_nettype wire

FILE: design/wpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module wpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/wpm_ctrl.sv
// Controller state machine for the wildcard pattern matcher.
// Depends on wpm_pkg.
`default_nettype none

module wpm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire logic [1:0]        cmd,
    input  wire wpm_pkg::wpm_stat_t stat,
    output logic                   cmd_stall,
    output wpm_pkg::wpm_ctl_t      ctl
);

    import wpm_pkg::*;

    wpm_state_t state_reg;
    wpm_state_t state_next;
    logic       accept;

    // A request is taken only while the controller is idle.
    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && (state_reg == ST_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_INIT:
            begin
                // Arm the match vector for the empty pattern after reset.
                ctl.scan_start = 1'b1;
                ctl.scan_rearm = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_CLEAR:
                        begin
                            ctl.clear_pat  = 1'b1;
                            ctl.scan_start = 1'b1;
                            ctl.scan_rearm = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        CMD_APPEND:
                        begin
                            ctl.append     = 1'b1;
                            ctl.scan_start = 1'b1;
                            ctl.scan_rearm = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        CMD_TEXT:
                        begin
                            ctl.load_char  = 1'b1;
                            ctl.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        CMD_END:
                        begin
                            ctl.end_addr = 1'b1;
                            state_next   = ST_END_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Issue one pattern position per cycle up to the pattern length.
                ctl.issue = 1'b1;
                if (stat.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last position is written back in this cycle.
                state_next = ST_IDLE;
            end
            ST_END_READ:
            begin
                state_next = ST_END_OUT;
            end
            ST_END_OUT:
            begin
                // Hand over the result, then rearm for the next text.
                if (stat.out_free)
                begin
                    ctl.out_load   = 1'b1;
                    ctl.scan_start = 1'b1;
                    ctl.scan_rearm = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/wpm_dpath.sv
// Datapath of the wildcard pattern matcher: pattern store, match vector
// store, the per-position update cell and the result register.
// Depends on wpm_pkg and wpm_ram.
`default_nettype none

module wpm_dpath #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    byte_value,
    input  wire wpm_pkg::wpm_ctl_t ctl,
    output wpm_pkg::wpm_stat_t stat,
    input  wire logic          result_stall,
    output logic               result_valid,
    output logic               matched,
    output logic               overflow
);

    import wpm_pkg::*;

    // Length counter and vector index width; pattern address width.
    localparam int LW  = $clog2(PATTERN_MAX + 1);
    localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [LW-1:0]  len_reg;
    logic [LW-1:0]  len_next;
    logic           ovf_reg;
    logic           ovf_next;
    logic [7:0]     char_reg;
    logic           mode_reg;
    logic [LW-1:0]  idx_reg;
    logic [LW-1:0]  idx_next;
    logic [LW-1:0]  idx_m1;
    logic           proc_valid_reg;
    logic [LW-1:0]  proc_idx_reg;
    logic           newprev_reg;
    logic           oldprev_reg;
    logic           new_bit;
    logic           has_room;
    logic           pat_we;
    logic [7:0]     pat_rdata;
    logic           vec_rdata;
    logic           is_star;
    logic           is_hit;
    logic           out_valid_reg;
    logic           matched_reg;
    logic           overflow_reg;

    assign has_room = (len_reg < LW'(PATTERN_MAX));
    assign pat_we   = ctl.append && has_room;
    assign idx_m1   = idx_reg - LW'(1);

    // Pattern store: written on append, read one position behind the index.
    wpm_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_MAX)
    ) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (len_reg[PAW-1:0]),
        .wdata (byte_value),
        .raddr (idx_m1[PAW-1:0]),
        .rdata (pat_rdata)
    );

    // Match vector store: one bit per pattern prefix length.
    wpm_ram #(
        .WIDTH (1),
        .DEPTH (PATTERN_MAX + 1)
    ) u_vec_ram (
        .clk   (clk),
        .we    (proc_valid_reg),
        .waddr (proc_idx_reg),
        .wdata (new_bit),
        .raddr (idx_reg),
        .rdata (vec_rdata)
    );

    // Pattern length and overflow flag.
    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (ctl.clear_pat)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        else if (ctl.append)
        begin
            if (has_room)
            begin
                len_next = len_reg + LW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    // Position counter: restarts for a scan, steps per issued read, or
    // points at the pattern end for a result read.
    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.scan_start)
        begin
            idx_next = '0;
        end
        else if (ctl.end_addr)
        begin
            idx_next = len_reg;
        end
        else if (ctl.issue && !stat.last_issue)
        begin
            idx_next = idx_reg + LW'(1);
        end
    end

    assign stat.last_issue = (idx_reg == len_reg);
    assign stat.out_free   = !out_valid_reg || !result_stall;

    // Read data arrives in the cycle after the issue; track that position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_valid_reg <= 1'b0;
        end
        else
        begin
            proc_valid_reg <= ctl.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        proc_idx_reg <= idx_reg;
        if (ctl.load_char)
        begin
            char_reg <= byte_value;
        end
        if (ctl.scan_start)
        begin
            mode_reg <= ctl.scan_rearm;
        end
        if (proc_valid_reg)
        begin
            newprev_reg <= new_bit;
            oldprev_reg <= vec_rdata;
        end
    end

    // Update cell: the new bit of one position from its old bit, the new
    // bit and old bit of the position before it, and the pattern byte.
    assign is_star = (pat_rdata == STAR_BYTE);
    assign is_hit  = (pat_rdata == QMARK_BYTE) || (pat_rdata == char_reg);

    always_comb
    begin
        if (proc_idx_reg == '0)
        begin
            new_bit = mode_reg;
        end
        else if (mode_reg)
        begin
            new_bit = newprev_reg && is_star;
        end
        else if (is_star)
        begin
            new_bit = newprev_reg || vec_rdata;
        end
        else
        begin
            new_bit = oldprev_reg && is_hit;
        end
    end

    // Result register: holds one result until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            matched_reg  <= vec_rdata && !ovf_reg;
            overflow_reg <= ovf_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign matched      = matched_reg;
    assign overflow     = overflow_reg;

endmodule

`default_nettype wire

FILE: design/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: controller plus datapath.
// Depends on wpm_pkg, wpm_ctrl, wpm_dpath and wpm_ram.
//
//   Channel  Handshake               Payload
//   request  cmd_valid / cmd_stall     cmd[1:0], byte_value[7:0]
//   result   result_valid / result_stall  matched, overflow
//
// A text byte request runs a scan: the update cell walks the pattern
// positions one per cycle through the pattern and match vector RAM read
// ports. An append runs the scan over the pattern with the new byte, and a
// clear over the empty pattern. An end-of-text request reads the result bit,
// waits on any result-side stall, then rearms with a scan. After reset the
// block arms the match vector before the first request is taken. A result
// waits in its register while the block goes on; only the next end-of-text
// request waits for it to be taken.
`default_nettype none

module wildcard_pattern_matcher #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_stall,
    input  wire logic [1:0] cmd,
    input  wire logic [7:0] byte_value,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            matched,
    output logic            overflow
);

    import wpm_pkg::*;

    wpm_ctl_t  ctl;
    wpm_stat_t stat;

    // Sequencer.
    wpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .stat      (stat),
        .cmd_stall (cmd_stall),
        .ctl       (ctl)
    );

    // Stores, update cell and result register.
    wpm_dpath #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_value   (byte_value),
        .ctl          (ctl),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .matched      (matched),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire
